### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/alide_pkg.sv
// Shared constants, codes and types of the array list engine
package alide_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_SORTED  = 3'd1;
    localparam logic [2:0] ACT_DELETE  = 3'd2;
    localparam logic [2:0] ACT_REVERSE = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

### rtl/array_list_insert_delete_engine_core.sv
// Top level of the array list insert, delete, reverse and read engine
//
// One transaction at a time walks a 64-entry list through a single memory
// port pair: one read and one write per cycle. Insert at position p shifts
// the entries from p upward by one, a sorted insert shifts every entry
// greater than the new value, a delete walks the whole list and closes the
// gap behind the match, a reverse of positions lo..hi swaps pairs inward,
// a read fetches one entry, and a rejected request goes straight to done.
// The result sits in an output register, so a new transaction is taken as
// soon as the engine is back in idle even while the last result waits.
module array_list_insert_delete_engine_core
    import alide_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_action,
    input  logic [5:0]               i_position,
    input  logic [5:0]               i_position_end,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_element_count,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [5:0]               o_placed_at
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UP    = 4'd1;
    localparam logic [3:0] S_PLACE = 4'd2;
    localparam logic [3:0] S_DEL   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_RV_B  = 4'd5;
    localparam logic [3:0] S_RV_C  = 4'd6;
    localparam logic [3:0] S_RV_D  = 4'd7;
    localparam logic [3:0] S_RV_E  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [IDX_W-1:0]  r_lim, n_lim;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_hi, n_hi;
    logic [IDX_W-1:0]  r_wa, n_wa;
    logic [IDX_W-1:0]  r_place, n_place;
    logic              r_sorted, n_sorted;
    logic              r_found, n_found;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic [1:0]        r_res_status, n_res_status;
    logic [DATA_W-1:0] r_res_rd, n_res_rd;
    logic [IDX_W-1:0]  r_res_place, n_res_place;

    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [CNT_W-1:0]  r_ocount;
    logic [DATA_W-1:0] r_ord;
    logic [IDX_W-1:0]  r_oplace;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] rdata;
    logic              cmp_gt;
    logic              cmp_eq;
    logic              accept;
    logic              out_load;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  pend_ext;
    logic              full;
    logic [IDX_W-1:0]  lo_nx;
    logic [IDX_W-1:0]  hi_nx;
    logic              hit;
    logic              last;

    alide_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign cmp_gt   = $signed(rdata) > $signed(r_val);
    assign cmp_eq   = rdata == r_val;
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_ovalid || !i_stall);
    assign pos_ext  = CNT_W'(i_position);
    assign pend_ext = CNT_W'(i_position_end);
    assign full     = r_count == CNT_W'(CAPACITY);
    assign lo_nx    = r_lo + IDX_W'(1);
    assign hi_nx    = r_hi - IDX_W'(1);
    assign hit      = !r_found && cmp_eq;
    assign last     = CNT_W'(r_j) == (r_count - CNT_W'(1));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_j          = r_j;
        n_lim        = r_lim;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_wa         = r_wa;
        n_place      = r_place;
        n_sorted     = r_sorted;
        n_found      = r_found;
        n_val        = r_val;
        n_tmp        = r_tmp;
        n_res_status = r_res_status;
        n_res_rd     = r_res_rd;
        n_res_place  = r_res_place;
        mem_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val        = i_item_value;
                    n_res_status = ST_OK;
                    n_res_rd     = '0;
                    n_res_place  = '0;
                    n_state      = S_DONE;
                    case (i_action)
                        ACT_INSERT: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else if (pos_ext > r_count) begin
                                n_res_status = ST_BADPOS;
                            end else if (pos_ext == r_count) begin
                                n_j     = IDX_W'(i_position);
                                n_state = S_PLACE;
                            end else begin
                                mem_req.raddr = IDX_W'(r_count - CNT_W'(1));
                                n_j           = IDX_W'(r_count - CNT_W'(1));
                                n_lim         = IDX_W'(i_position);
                                n_sorted      = 1'b0;
                                n_state       = S_UP;
                            end
                        end
                        ACT_SORTED: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else if (r_count == '0) begin
                                n_j     = '0;
                                n_state = S_PLACE;
                            end else begin
                                mem_req.raddr = IDX_W'(r_count - CNT_W'(1));
                                n_j           = IDX_W'(r_count - CNT_W'(1));
                                n_lim         = '0;
                                n_sorted      = 1'b1;
                                n_state       = S_UP;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_NOTFOUND;
                            end else begin
                                mem_req.raddr = '0;
                                n_j           = '0;
                                n_found       = 1'b0;
                                n_state       = S_DEL;
                            end
                        end
                        ACT_REVERSE: begin
                            if (i_position <= i_position_end) begin
                                if (pend_ext >= r_count) begin
                                    n_res_status = ST_BADPOS;
                                end else if (i_position < i_position_end) begin
                                    mem_req.raddr = IDX_W'(i_position);
                                    n_lo          = IDX_W'(i_position);
                                    n_hi          = IDX_W'(i_position_end);
                                    n_state       = S_RV_B;
                                end
                            end
                        end
                        ACT_READ: begin
                            if (pos_ext >= r_count) begin
                                n_res_status = ST_BADPOS;
                            end else begin
                                mem_req.raddr = IDX_W'(i_position);
                                n_state       = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_j + IDX_W'(1);
                if (!r_sorted || cmp_gt) begin
                    mem_req.wdata = rdata;
                    if (r_j == r_lim) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_req.raddr = r_j - IDX_W'(1);
                        n_j           = r_j - IDX_W'(1);
                    end
                end else begin
                    mem_req.wdata = r_val;
                    n_count       = r_count + CNT_W'(1);
                    n_res_place   = r_j + IDX_W'(1);
                    n_state       = S_DONE;
                end
            end
            S_PLACE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_j;
                mem_req.wdata = r_val;
                n_count       = r_count + CNT_W'(1);
                n_res_place   = r_j;
                n_state       = S_DONE;
            end
            S_DEL: begin
                if (r_found) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_j - IDX_W'(1);
                    mem_req.wdata = rdata;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_place = r_j;
                end
                if (last) begin
                    if (r_found || hit) begin
                        n_count     = r_count - CNT_W'(1);
                        n_res_place = hit ? r_j : r_place;
                    end else begin
                        n_res_status = ST_NOTFOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    mem_req.raddr = r_j + IDX_W'(1);
                    n_j           = r_j + IDX_W'(1);
                end
            end
            S_RD: begin
                n_res_rd = rdata;
                n_state  = S_DONE;
            end
            S_RV_B: begin
                mem_req.raddr = r_hi;
                n_tmp         = rdata;
                n_state       = S_RV_C;
            end
            S_RV_C: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_lo;
                mem_req.wdata = rdata;
                n_wa          = r_hi;
                n_lo          = lo_nx;
                n_hi          = hi_nx;
                if (lo_nx < hi_nx) begin
                    mem_req.raddr = lo_nx;
                    n_state       = S_RV_D;
                end else begin
                    n_state = S_RV_E;
                end
            end
            S_RV_D: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_wa;
                mem_req.wdata = r_tmp;
                mem_req.raddr = r_hi;
                n_tmp         = rdata;
                n_state       = S_RV_C;
            end
            S_RV_E: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_wa;
                mem_req.wdata = r_tmp;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_lim        <= n_lim;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_wa         <= n_wa;
        r_place      <= n_place;
        r_sorted     <= n_sorted;
        r_found      <= n_found;
        r_val        <= n_val;
        r_tmp        <= n_tmp;
        r_res_status <= n_res_status;
        r_res_rd     <= n_res_rd;
        r_res_place  <= n_res_place;
        if (out_load) begin
            r_ostatus <= r_res_status;
            r_ocount  <= r_count;
            r_ord     <= r_res_rd;
            r_oplace  <= r_res_place;
        end
    end

    assign o_stall         = r_state != S_IDLE;
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_element_count = r_ocount;
    assign o_read_value    = $signed(r_ord);
    assign o_placed_at     = 6'(r_oplace);

endmodule

### rtl/alide_ram.sv
// List storage: one write port, one registered read port
module alide_ram
    import alide_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/alide_checker.sv
// Port-level checker for the array list engine, bound to the top level
`include "assert_macros.svh"

module alide_checker
    import alide_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic [2:0]               i_action,
    input logic [5:0]               i_position,
    input logic [5:0]               i_position_end,
    input logic signed [DATA_W-1:0] i_item_value,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [1:0]               o_status,
    input logic [CNT_W-1:0]         o_element_count,
    input logic signed [DATA_W-1:0] o_read_value,
    input logic [5:0]               o_placed_at
);

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_rst_n && i_valid && !o_stall, o_stall)
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_element_count) && $stable(o_read_value) && $stable(o_placed_at))
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, o_valid, o_element_count <= CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), o_element_count == CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_read_value == '0) && (o_placed_at == '0))

endmodule

bind array_list_insert_delete_engine_core alide_checker u_alide_checker (.*);
